@@ design/fdsa_pkg.sv @@
// Shared types and constants for the Forth data stack ALU block.
// No dependencies; imported by the controller, the datapath and the top level.
package fdsa_pkg;

  localparam int DATA_W = 8;

  typedef enum logic [3:0] {
    CMD_PUSH = 4'd0,
    CMD_POP  = 4'd1,
    CMD_DUP  = 4'd2,
    CMD_SWAP = 4'd3,
    CMD_ROT  = 4'd4,
    CMD_ADD  = 4'd5,
    CMD_SUB  = 4'd6,
    CMD_MUL  = 4'd7,
    CMD_DIV  = 4'd8,
    CMD_EQ   = 4'd9,
    CMD_NEQ  = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]               command;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [7:0]               depth;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/fdsa_ctrl.sv @@
// Sequencer for the Forth data stack ALU: accept, execute, divide, commit.
// Depends on fdsa_pkg for the command and status structs.
module fdsa_ctrl
  import fdsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.need_div) begin
          ctrl_o.div_start = 1'b1;
          state_d          = S_DIV;
        end else if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DIV: begin
        if (!stat_i.div_done) begin
          ctrl_o.div_step = 1'b1;
        end else if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/fdsa_dpath.sv @@
// Datapath: top three entries cached in registers, deeper entries in a RAM,
// ALU with a bit-serial divider, and the result register. Uses fdsa_pkg.
module fdsa_dpath
  import fdsa_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  ctrl_cmd_t ctrl_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int DCW = $clog2(DATA_W + 1);

  // item registers
  logic [3:0]               cmd_q;
  logic signed [DATA_W-1:0] pv_q;

  // cached top entries and entry count
  logic signed [DATA_W-1:0] t0_q, t1_q, t2_q, t0_d, t1_d, t2_d;
  logic [CW-1:0]            count_q, count_d;

  // deeper entries: entry i lives at address i while count > i + 3
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              mem_we;

  // divider
  logic [DATA_W-1:0] div_rem_q, div_quo_q, div_dvs_q;
  logic              div_neg_q;
  logic [DCW-1:0]    div_cnt_q;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] rem_diff;
  logic [DATA_W-1:0] mag_a, mag_b;
  logic signed [DATA_W-1:0] quot;

  // ALU
  logic signed [2*DATA_W-1:0] prod;
  logic signed [DATA_W-1:0]   alu_r;
  logic [1:0]                 need;
  logic                       unf, ovf, dz;
  status_e                    status;
  logic                       popped;
  logic signed [DATA_W-1:0]   data_d;

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;

  assign rd_addr = AW'({1'b0, count_q} - (CW + 1)'(4));
  assign wr_addr = AW'({1'b0, count_q} - (CW + 1)'(3));

  always_ff @(posedge clk_i) begin
    rd_data_q <= stack_mem[rd_addr];
    if (ctrl_i.commit && mem_we) begin
      stack_mem[wr_addr] <= t2_q;
    end
  end

  // ---- status checks ----
  always_comb begin
    case (cmd_q)
      CMD_PUSH:          need = 2'd0;
      CMD_POP, CMD_DUP:  need = 2'd1;
      CMD_ROT:           need = 2'd3;
      CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_NEQ: need = 2'd2;
      default:           need = 2'd0;
    endcase
  end

  assign unf = (count_q < CW'(need));
  assign ovf = ((cmd_q == CMD_PUSH) || (cmd_q == CMD_DUP)) && (count_q == CW'(STACK_DEPTH));
  assign dz  = (cmd_q == CMD_DIV) && (t0_q == '0);

  always_comb begin
    if (unf)      status = ST_UNDERFLOW;
    else if (ovf) status = ST_OVERFLOW;
    else if (dz)  status = ST_DIVZERO;
    else          status = ST_OK;
  end

  // ---- divider: restoring, one quotient bit per step on magnitudes ----
  assign mag_a    = t0_q[DATA_W-1] ? DATA_W'(-t0_q) : DATA_W'(t0_q);
  assign mag_b    = t1_q[DATA_W-1] ? DATA_W'(-t1_q) : DATA_W'(t1_q);
  assign rem_sh   = {div_rem_q, div_quo_q[DATA_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_dvs_q};
  assign quot     = div_neg_q ? DATA_W'(-div_quo_q) : DATA_W'(div_quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (ctrl_i.div_start) begin
      div_cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      div_cnt_q <= div_cnt_q + DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= mag_b;
      div_dvs_q <= mag_a;
      div_neg_q <= t0_q[DATA_W-1] ^ t1_q[DATA_W-1];
    end else if (ctrl_i.div_step) begin
      if (!rem_diff[DATA_W+1]) begin
        div_rem_q <= DATA_W'(rem_diff);
        div_quo_q <= {div_quo_q[DATA_W-2:0], 1'b1};
      end else begin
        div_rem_q <= DATA_W'(rem_sh);
        div_quo_q <= {div_quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  // ---- ALU: b is below the top, a is the top ----
  assign prod = t1_q * t0_q;

  always_comb begin
    case (cmd_q)
      CMD_ADD: alu_r = t1_q + t0_q;
      CMD_SUB: alu_r = t1_q - t0_q;
      CMD_MUL: alu_r = prod[DATA_W-1:0];
      CMD_DIV: alu_r = quot;
      CMD_EQ:  alu_r = DATA_W'(t1_q == t0_q);
      CMD_NEQ: alu_r = DATA_W'(t1_q != t0_q);
      default: alu_r = '0;
    endcase
  end

  // ---- next stack state ----
  always_comb begin
    t0_d    = t0_q;
    t1_d    = t1_q;
    t2_d    = t2_q;
    count_d = count_q;
    mem_we  = 1'b0;
    popped  = 1'b0;
    if (status == ST_OK) begin
      case (cmd_q)
        CMD_PUSH, CMD_DUP: begin
          t0_d    = (cmd_q == CMD_PUSH) ? pv_q : t0_q;
          t1_d    = t0_q;
          t2_d    = t1_q;
          mem_we  = (count_q >= CW'(3));
          count_d = count_q + CW'(1);
        end
        CMD_POP: begin
          popped  = 1'b1;
          t0_d    = t1_q;
          t1_d    = t2_q;
          t2_d    = rd_data_q;
          count_d = count_q - CW'(1);
        end
        CMD_SWAP: begin
          t0_d = t1_q;
          t1_d = t0_q;
        end
        CMD_ROT: begin
          t0_d = t1_q;
          t1_d = t2_q;
          t2_d = t0_q;
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_NEQ: begin
          t0_d    = alu_r;
          t1_d    = t2_q;
          t2_d    = rd_data_q;
          count_d = count_q - CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (popped)                data_d = t0_q;
    else if (count_d != '0)    data_d = t0_d;
    else                       data_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q <= in_item_i.command;
      pv_q  <= in_item_i.push_value;
    end
    if (ctrl_i.commit) begin
      t0_q <= t0_d;
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      out_item_q.status <= status;
      out_item_q.data   <= data_d;
      out_item_q.depth  <= 8'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;
  assign stat_o.need_div = (cmd_q == CMD_DIV) && (status == ST_OK);
  assign stat_o.div_done = (div_cnt_q == DCW'(DATA_W));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

endmodule

@@ design/forth_data_stack_alu_unit.sv @@
// Forth data stack ALU, top level: fdsa_ctrl sequencer plus fdsa_dpath.
// Items are registered on accept; the result is registered on commit, which
// waits while a stalled result is held, and div first runs the 8-step
// bit-serial divider. Input stalls until the item commits. The top-of-stack
// cache hides the RAM read latency. Reset empties the stack, not the RAM.
module forth_data_stack_alu_unit
  import fdsa_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  fdsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  fdsa_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // an accepted item keeps the input side busy until it commits
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.accept |=> in_stall_o)
    else $error("input not stalled after accept");

  // a commit always leaves a result in the output register
  a_commit_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> out_valid_o)
    else $error("commit produced no result");

  // a commit never overwrites a result that is still stalled
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten");

  // accept and commit belong to different phases of one item
  a_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.accept && (ctrl.commit || ctrl.div_step || ctrl.div_start)))
    else $error("accept overlaps execution");

endmodule
